FILE: rtl/rmsu_pkg.sv
// ----------------------------------------------------------------------------
// rmsu_pkg
// Shared widths, register indexes, reset values and pipeline types of the
// RMSprop update unit, and its square root step.
// ----------------------------------------------------------------------------
package rmsu_pkg;

  localparam int GRAD_W      = 32;
  localparam int SLOT_IDX_W  = 12;
  localparam int MOMENT_W    = 48;
  localparam int NUM_W       = 56;
  localparam int ROOT_W      = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [MOMENT_W-1:0] MOMENT_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [23:0] LR_RESET      = 24'd16777;
  localparam logic [15:0] DECAY_RESET   = 16'd58982;
  localparam logic [15:0] GAIN_RESET    = 16'd6554;
  localparam logic [31:0] EPSILON_RESET = 32'd4295;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEARNING_RATE = 8'd0,
    REG_DECAY         = 8'd1,
    REG_GAIN          = 8'd2,
    REG_EPSILON       = 8'd3
  } cfg_reg_t;

  // Data that rides along the root and divide pipelines.
  typedef struct packed {
    logic              neg;
    logic [GRAD_W-1:0] mag;
    logic [NUM_W-1:0]  num;
    logic              clip;
  } rmsu_side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sqrt_state_t;

  // One step of the bit-pair integer square root.
  function automatic sqrt_state_t sqrt_step(sqrt_state_t st, logic [63:0] b);
    sqrt_state_t nx;
    logic [63:0] trial;
    trial = st.res + b;
    nx = st;
    if (st.rem >= trial) begin
      nx.rem = st.rem - trial;
      nx.res = (st.res >> 1) + b;
    end else begin
      nx.res = st.res >> 1;
    end
    return nx;
  endfunction

endpackage

FILE: rtl/rmsu_ifs.sv
// ----------------------------------------------------------------------------
// rmsu_ifs
// Valid/ready channels of the RMSprop update unit: gradients in, steps out,
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface rmsu_grad_if import rmsu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [GRAD_W-1:0] grad_value;
  logic [SLOT_IDX_W-1:0]   slot_index;
  modport source (output valid, grad_value, slot_index, input ready);
  modport sink   (input valid, grad_value, slot_index, output ready);
endinterface

interface rmsu_step_if import rmsu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [GRAD_W-1:0] step_value;
  logic                    clipped;
  modport source (output valid, step_value, clipped, input ready);
  modport sink   (input valid, step_value, clipped, output ready);
endinterface

interface rmsu_cfg_if import rmsu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  reg_data;
  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

FILE: rtl/rmsprop_update_unit.sv
// ----------------------------------------------------------------------------
// rmsprop_update_unit
// RMSprop step engine: per-slot second-moment update and scaled step output.
// ----------------------------------------------------------------------------
// The unit takes one gradient per clock while the output queue is not full
// and returns one step per gradient in order; a result passes five front
// stages, sixteen root stages, sixteen divide stages and one output queue
// stage, and the pipeline stalls while that queue is full. Throughput is
// set by the moment memory read-modify-write, which completes in one stage
// with forwarding so that repeated slots still run at full rate.
// After reset the unit sweeps the moment memory to zero, one slot per cycle,
// and grad_in.ready stays low until the sweep is done; configuration
// writes are taken at any time but must only be issued while idle.
module rmsprop_update_unit import rmsu_pkg::*; #(
  parameter int SLOTS = 4096
) (
  input  logic         clk,
  input  logic         rst,
  rmsu_grad_if.sink    grad_in,
  rmsu_step_if.source  step_out,
  rmsu_cfg_if.sink     cfg
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic signed [GRAD_W-1:0] step;
    logic                     clipped;
  } result_t;

  // Configuration registers
  logic [23:0] learning_rate;
  logic [15:0] decay;
  logic [15:0] gain;
  logic [31:0] epsilon;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      decay         <= DECAY_RESET;
      gain          <= GAIN_RESET;
      epsilon       <= EPSILON_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_LEARNING_RATE: learning_rate <= cfg.reg_data[23:0];
        REG_DECAY:         decay         <= cfg.reg_data[15:0];
        REG_GAIN:          gain          <= cfg.reg_data[15:0];
        REG_EPSILON:       epsilon       <= cfg.reg_data;
        default: ;
      endcase
    end
  end

  // Slot reduction modulo SLOTS by conditional subtraction of shifted copies.
  function automatic logic [SLOT_IDX_W-1:0] mod_steps(logic [SLOT_IDX_W-1:0] x,
                                                      int hi, int lo);
    logic [SLOT_IDX_W-1:0] r;
    longint                m;
    r = x;
    for (int k = hi; k >= lo; k--) begin
      m = longint'(SLOTS) << k;
      if (m < (longint'(1) << SLOT_IDX_W) && r >= SLOT_IDX_W'(m)) begin
        r = r - SLOT_IDX_W'(m);
      end
    end
    return r;
  endfunction

  // Control
  logic              en;
  logic              accept;
  logic              clr_active;
  logic [SLOT_W-1:0] clr_addr;
  logic [1:0]        cnt;
  logic [1:0]        cnt_next;
  logic              push;
  logic              pop;

  assign en            = (cnt != 2'd2);
  assign grad_in.ready = en && !clr_active;
  assign accept        = grad_in.valid && grad_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == SLOT_W'(SLOTS - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Stage 1: magnitude, sign and first half of slot reduction
  logic                  p1_valid;
  logic                  p1_neg;
  logic [GRAD_W-1:0]     p1_mag;
  logic [SLOT_IDX_W-1:0] p1_slot;
  logic [GRAD_W-1:0]     graw;

  assign graw = grad_in.grad_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_neg  <= graw[GRAD_W-1];
      p1_mag  <= graw[GRAD_W-1] ? (~graw + 32'd1) : graw;
      p1_slot <= mod_steps(grad_in.slot_index, SLOT_IDX_W - 1, SLOT_IDX_W / 2);
    end
  end

  // Stage 2: gradient squared and final slot
  logic              p2_valid;
  logic              p2_neg;
  logic [GRAD_W-1:0] p2_mag;
  logic [62:0]       p2_g2;
  logic [SLOT_W-1:0] p2_slot;
  logic [63:0]       sq_prod;

  assign sq_prod = {32'd0, p1_mag} * {32'd0, p1_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_neg  <= p1_neg;
      p2_mag  <= p1_mag;
      p2_g2   <= sq_prod[62:0];
      p2_slot <= SLOT_W'(mod_steps(p1_slot, SLOT_IDX_W / 2 - 1, 0));
    end
  end

  // Stage 3: gain term
  logic              p3_valid;
  logic              p3_neg;
  logic [GRAD_W-1:0] p3_mag;
  logic [61:0]       p3_t2;
  logic [SLOT_W-1:0] p3_slot;
  logic [77:0]       gain_prod;

  assign gain_prod = {62'd0, gain} * {15'd0, p2_g2};

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_neg  <= p2_neg;
      p3_mag  <= p2_mag;
      p3_t2   <= gain_prod[77:16];
      p3_slot <= p2_slot;
    end
  end

  // Stage 4: moment read-modify-write
  logic                p4_valid;
  logic                p4_neg;
  logic [GRAD_W-1:0]   p4_mag;
  logic [61:0]         p4_t2;
  logic [SLOT_W-1:0]   p4_slot;
  logic [MOMENT_W-1:0] rdata;
  logic [MOMENT_W-1:0] moment_mem [SLOTS];

  logic                fwd_valid;
  logic [SLOT_W-1:0]   fwd_slot;
  logic [MOMENT_W-1:0] fwd_v;

  logic [MOMENT_W-1:0] v_old;
  logic [63:0]         decay_prod;
  logic [62:0]         v_sum;
  logic                v_sat;
  logic [MOMENT_W-1:0] v_new;
  logic [NUM_W-1:0]    num;

  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [MOMENT_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (en) begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_neg  <= p3_neg;
      p4_mag  <= p3_mag;
      p4_t2   <= p3_t2;
      p4_slot <= p3_slot;
    end
  end

  // The last write holds the newest value of its slot, so it overrides the
  // memory read whenever the slots match.
  assign v_old      = (fwd_valid && fwd_slot == p4_slot) ? fwd_v : rdata;
  assign decay_prod = {48'd0, decay} * {16'd0, v_old};
  assign v_sum      = {15'd0, decay_prod[63:16]} + {1'b0, p4_t2};
  assign v_sat      = (v_sum > {15'd0, MOMENT_MAX});
  assign v_new      = v_sat ? MOMENT_MAX : v_sum[MOMENT_W-1:0];
  assign num        = {32'd0, learning_rate} * {24'd0, p4_mag};

  assign mem_we    = clr_active || (en && p4_valid);
  assign mem_waddr = clr_active ? clr_addr : p4_slot;
  assign mem_wdata = clr_active ? '0 : v_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      moment_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= moment_mem[p3_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (clr_active) begin
      fwd_valid <= 1'b0;
    end else if (en && p4_valid) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p4_valid) begin
      fwd_slot <= p4_slot;
      fwd_v    <= v_new;
    end
  end

  // Stage 5: moment plus epsilon into the root pipeline
  logic                p5_valid;
  logic [MOMENT_W-1:0] p5_v;
  rmsu_side_t          p5_side;
  logic [MOMENT_W:0]   s_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else if (en) begin
      p5_valid <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_v         <= v_new;
      p5_side.neg  <= p4_neg;
      p5_side.mag  <= p4_mag;
      p5_side.num  <= num;
      p5_side.clip <= v_sat;
    end
  end

  assign s_sum = {1'b0, p5_v} + {17'd0, epsilon};

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  rmsu_side_t        sq_side;

  rmsu_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p5_valid),
    .x         ({s_sum, 14'd0}),
    .in_side   (p5_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  logic                     div_valid;
  logic signed [GRAD_W-1:0] div_step;
  logic                     div_clipped;

  rmsu_div_pipe u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sq_valid),
    .root       (sq_root),
    .in_side    (sq_side),
    .out_valid  (div_valid),
    .step_value (div_step),
    .clipped    (div_clipped)
  );

  // Two-entry output queue; the pipeline keeps moving while one result waits.
  result_t fifo_mem [2];
  logic    wr_ptr;
  logic    rd_ptr;

  assign push     = en && div_valid;
  assign pop      = step_out.valid && step_out.ready;
  assign cnt_next = cnt + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{step: div_step, clipped: div_clipped};
    end
  end

  assign step_out.valid      = (cnt != 2'd0);
  assign step_out.step_value = fifo_mem[rd_ptr].step;
  assign step_out.clipped    = fifo_mem[rd_ptr].clipped;

  // Assertions
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !grad_in.ready)
    else $error("input ready while the moment memory is being cleared");

  a_clear_no_update: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !(en && p4_valid))
    else $error("moment update collides with the clearing sweep");

  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (cnt == $past(cnt) + 2'd1))
    else $error("output queue count lost a push");

  a_forward_tracks: assert property (@(posedge clk) disable iff (rst)
    (en && p4_valid && !clr_active) |=> (fwd_valid && fwd_slot == $past(p4_slot)))
    else $error("forwarding register missed a moment write");

endmodule

FILE: rtl/rmsu_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rmsu_sqrt_pipe
// Pipelined floor square root of a 63-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module rmsu_sqrt_pipe import rmsu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [62:0]       x,
  input  rmsu_side_t        in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output rmsu_side_t        out_side
);

  localparam int ITERS     = 32;
  localparam int PER_STAGE = 2;
  localparam int STAGES    = ITERS / PER_STAGE;

  logic        valid_q  [STAGES];
  sqrt_state_t st_q     [STAGES];
  rmsu_side_t  side_q   [STAGES];
  logic        valid_in [STAGES];
  sqrt_state_t st_in    [STAGES];
  rmsu_side_t  side_in  [STAGES];
  sqrt_state_t st_next  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign valid_in[s] = in_valid;
      assign st_in[s]    = {{1'b0, x}, 64'd0};
      assign side_in[s]  = in_side;
    end else begin : g_rest
      assign valid_in[s] = valid_q[s-1];
      assign st_in[s]    = st_q[s-1];
      assign side_in[s]  = side_q[s-1];
    end

    always_comb begin
      sqrt_state_t cur;
      cur = st_in[s];
      for (int j = 0; j < PER_STAGE; j++) begin
        cur = sqrt_step(cur, 64'd1 << (62 - 2 * (s * PER_STAGE + j)));
      end
      st_next[s] = cur;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s] <= 1'b0;
      end else if (en) begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_q[s]   <= st_next[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign out_valid = valid_q[STAGES-1];
  assign root      = st_q[STAGES-1].res[ROOT_W-1:0];
  assign out_side  = side_q[STAGES-1];

endmodule

FILE: rtl/rmsu_div_pipe.sv
// ----------------------------------------------------------------------------
// rmsu_div_pipe
// Pipelined restoring divide of lr*|g| by twice the root, two quotient bits
// per stage, followed by saturation and sign restore.
// ----------------------------------------------------------------------------
module rmsu_div_pipe import rmsu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [ROOT_W-1:0]        root,
  input  rmsu_side_t               in_side,
  output logic                     out_valid,
  output logic signed [GRAD_W-1:0] step_value,
  output logic                     clipped
);

  localparam int QBITS     = 32;
  localparam int PER_STAGE = 2;
  localparam int STAGES    = QBITS / PER_STAGE;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [ROOT_W:0]   den;
    logic [QBITS-1:0]  quo;
    logic              ovf;
    logic              neg;
    logic              clip;
  } div_state_t;

  logic       valid_q  [STAGES];
  div_state_t st_q     [STAGES];
  logic       valid_in [STAGES];
  div_state_t st_in    [STAGES];
  div_state_t st_next  [STAGES];
  div_state_t init_st;

  // A zero root only divides cleanly when the gradient is zero as well. The
  // divisor is then replaced by all ones so that a zero numerator leaves a
  // zero quotient; a nonzero gradient saturates through the overflow flag.
  always_comb begin
    init_st.den  = {root, 1'b0};
    init_st.rem  = in_side.num;
    init_st.quo  = '0;
    init_st.neg  = in_side.neg;
    init_st.clip = in_side.clip;
    if (root == '0) begin
      init_st.den = '1;
      init_st.ovf = (in_side.mag != '0);
    end else begin
      init_st.ovf = ({9'd0, in_side.num} >= {init_st.den, 32'd0});
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign valid_in[s] = in_valid;
      assign st_in[s]    = init_st;
    end else begin : g_rest
      assign valid_in[s] = valid_q[s-1];
      assign st_in[s]    = st_q[s-1];
    end

    always_comb begin
      div_state_t  cur;
      logic [63:0] sh;
      cur = st_in[s];
      for (int j = 0; j < PER_STAGE; j++) begin
        sh = {31'd0, cur.den} << (QBITS - 1 - (s * PER_STAGE + j));
        if ({8'd0, cur.rem} >= sh) begin
          cur.rem = cur.rem - sh[NUM_W-1:0];
          cur.quo[QBITS - 1 - (s * PER_STAGE + j)] = 1'b1;
        end
      end
      st_next[s] = cur;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s] <= 1'b0;
      end else if (en) begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_q[s] <= st_next[s];
      end
    end
  end

  always_comb begin
    div_state_t       last;
    logic [QBITS-1:0] limit;
    logic [QBITS-1:0] q;
    logic             sat;
    last  = st_q[STAGES-1];
    limit = last.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat   = last.ovf || (last.quo > limit);
    q     = sat ? limit : last.quo;
    step_value = last.neg ? signed'(~q + 32'd1) : signed'(q);
    clipped    = last.clip | sat;
  end

  assign out_valid = valid_q[STAGES-1];

endmodule

FILE: verif/tb_rmsprop_update_unit.sv
// ----------------------------------------------------------------------------
// tb_rmsprop_update_unit
// Self-checking bench for the RMSprop update unit. Gradients are sent over a
// valid/ready channel with random gaps, steps are taken with random stalls,
// and each step is compared with a local model of the moment store.
// ----------------------------------------------------------------------------
module tb_rmsprop_update_unit;
  import rmsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 4096;
  localparam int LATENCY = 38;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] step;
    logic               clip;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmsu_grad_if grad_ch ();
  rmsu_step_if step_ch ();
  rmsu_cfg_if  cfg_ch ();

  rmsprop_update_unit #(.SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst), .grad_in(grad_ch.sink), .step_out(step_ch.source),
    .cfg(cfg_ch.sink)
  );

  always #6 clk = ~clk;

  logic [23:0] lr_q;
  logic [15:0] decay_q;
  logic [15:0] gain_q;
  logic [31:0] eps_q;
  logic [47:0] moment_q [SLOTS];
  step_t       pending_steps [$];
  int          error_count = 0;
  int          steps_seen = 0;
  int          clipped_seen = 0;
  bit          stall_enable = 1'b1;
  longint      cycle_count = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_q;
    res = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > x) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (x >= res + bit_q) begin
        x = x - (res + bit_q);
        res = (res >> 1) + bit_q;
      end else begin
        res = res >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return res;
  endfunction

  // Updates the slot in the local store and returns the expected step.
  function automatic step_t predict_step(logic [31:0] g, logic [11:0] slot);
    step_t r;
    logic        neg;
    logic [63:0] mag, g2, t1, t2, v, d, q, lim;
    logic [127:0] t1w;
    neg = g[31];
    mag = neg ? {32'd0, -g} : {32'd0, g};
    if (neg && mag == 0) mag = 64'h8000_0000;
    g2 = mag * mag;
    t1w = 128'(decay_q) * 128'(moment_q[slot]);
    t1 = t1w[79:16];
    t2 = ((64'(gain_q) * (g2 >> 32)) << 16) + ((64'(gain_q) * g2[31:0]) >> 16);
    v = t1 + t2;
    r.clip = 1'b0;
    if (v > 64'(MOMENT_MAX)) begin
      v = 64'(MOMENT_MAX);
      r.clip = 1'b1;
    end
    moment_q[slot] = v[47:0];
    d = int_sqrt((v + 64'(eps_q)) << 14);
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (d == 0) begin
      if (mag == 0) q = 0;
      else begin
        q = lim;
        r.clip = 1'b1;
      end
    end else begin
      q = (64'(lr_q) * mag) / (2 * d);
      if (q > lim) begin
        q = lim;
        r.clip = 1'b1;
      end
    end
    r.step = neg ? -q[31:0] : q[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // The input valid drops only for an idle burst or a drain, so a transfer
  // that follows directly keeps valid high without a second update.
  task automatic idle_burst();
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      grad_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic send_grad(logic [31:0] g, logic [11:0] slot);
    idle_burst();
    grad_ch.valid <= 1'b1;
    grad_ch.grad_value <= g;
    grad_ch.slot_index <= slot;
    @(posedge clk);
    while (!grad_ch.ready) @(posedge clk);
    pending_steps.push_back(predict_step(g, slot));
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_LEARNING_RATE: lr_q = data[23:0];
      REG_DECAY:         decay_q = data[15:0];
      REG_GAIN:          gain_q = data[15:0];
      REG_EPSILON:       eps_q = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    grad_ch.valid <= 1'b0;
    while (pending_steps.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_config(logic [23:0] lr, logic [15:0] dc, logic [15:0] gn,
                            logic [31:0] ep);
    drain();
    write_reg(REG_LEARNING_RATE, 32'(lr));
    write_reg(REG_DECAY, 32'(dc));
    write_reg(REG_GAIN, 32'(gn));
    write_reg(REG_EPSILON, ep);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_grad(32'h0000_0000, 12'd0);
    send_grad(32'h0001_0000, 12'd1);
    send_grad(32'hFFFF_0000, 12'd1);
    send_grad(32'h7FFF_FFFF, 12'd2);
    send_grad(32'h8000_0000, 12'd3);
    send_grad(32'h8000_0000, 12'd3);
    send_grad(32'h0000_0001, 12'd4095);
    send_grad(32'hFFFF_FFFF, 12'd4095);
    send_grad(32'h0000_0000, 12'd0);
  endtask

  task automatic test_zero_root();
    set_config(24'hFFFFFF, 16'd0, 16'd0, 32'd0);
    send_grad(32'h0000_0000, 12'd10);
    send_grad(32'h0000_0005, 12'd11);
    send_grad(32'hFFFF_FFF0, 12'd12);
  endtask

  task automatic test_saturation();
    set_config(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_grad(32'h7FFF_FFFF, 12'd20);
    send_grad(32'h8000_0000, 12'd20);
    send_grad(32'h0000_0100, 12'd21);
    send_grad(32'hFFFF_FF00, 12'd22);
  endtask

  task automatic random_phase(int count, bit narrow_slots);
    logic [31:0] g;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: g = $urandom;
        1: g = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        2: g = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
        default: g = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 9)
                                          : 32'h8000_0000 + $urandom_range(0, 9);
      endcase
      send_grad(g, narrow_slots ? 12'($urandom_range(0, 7)) : 12'($urandom));
    end
  endtask

  task automatic test_random();
    set_config(LR_RESET, DECAY_RESET, GAIN_RESET, EPSILON_RESET);
    random_phase(150, 1'b1);
    set_config(24'($urandom), 16'($urandom), 16'($urandom), $urandom);
    random_phase(120, 1'b0);
    set_config(24'($urandom_range(1, 1 << 20)), 16'hE000, 16'h2000,
               32'($urandom_range(0, 1 << 16)));
    random_phase(130, 1'b1);
    stall_enable = 1'b0;
    random_phase(130, 1'b0);
  endtask

  always @(posedge clk) begin
    step_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && step_ch.valid && step_ch.ready) begin
      steps_seen++;
      if (step_ch.clipped) clipped_seen++;
      if (pending_steps.size() == 0) begin
        report_mismatch("unexpected step", step_ch.step_value, 32'd0);
      end else begin
        want = pending_steps.pop_front();
        if (step_ch.step_value !== want.step)
          report_mismatch("step_value", step_ch.step_value, want.step);
        if (step_ch.clipped !== want.clip)
          report_mismatch("clipped", 32'(step_ch.clipped), 32'(want.clip));
      end
    end
  end

  // Random backpressure on the result side.
  initial begin
    step_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_enable && $urandom_range(0, 5) == 0) begin
        step_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      step_ch.ready <= 1'b1;
    end
  end

  initial begin
    @(posedge clk);
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    grad_ch.valid = 1'b0;
    grad_ch.grad_value = '0;
    grad_ch.slot_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = REG_LEARNING_RATE;
    cfg_ch.reg_data = '0;
    lr_q = LR_RESET;
    decay_q = DECAY_RESET;
    gain_q = GAIN_RESET;
    eps_q = EPSILON_RESET;
    foreach (moment_q[i]) moment_q[i] = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_root();
    test_saturation();
    test_random();
    drain();
    $display("checked %0d steps (%0d clipped) across five register settings,",
             steps_seen, clipped_seen);
    $display("including zero-root, saturating and repeated-slot traffic.");
    if (error_count == 0 && pending_steps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
